>>> hdl/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation block.
`timescale 1ns / 1ps
package bpc_pkg;
  localparam int unsigned TrimW = 48;
  localparam int unsigned RawW  = 20;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegTempTrim = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPresA    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPresB    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPresC    = 2'd3;

  localparam logic [31:0] Offs64000 = 32'd64000;
  localparam logic [31:0] Offs32768 = 32'd32768;
  localparam logic [31:0] Offs2p20  = 32'd1048576;
  localparam logic [31:0] Scale3125 = 32'd3125;
  localparam logic [31:0] HalfRange = 32'h8000_0000;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } bpc_in_t;

  typedef struct packed {
    logic [31:0] pressure_pa;
    logic signed [31:0] fine_temperature;
    logic divide_guard;
  } bpc_out_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction
endpackage

>>> hdl/bpc_stream_if.sv
// Valid/ready channel carrying one payload.
`timescale 1ns / 1ps
interface bpc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/baro_pressure_compensation.sv
// Top level: pipelined 32-bit integer barometric pressure compensation.
`timescale 1ns / 1ps
// Takes one raw pressure/temperature pair per cycle unless stalled and
// returns the fine temperature and compensated pressure (Pa): eight
// multiply/add stages before the divide, a 32-stage divider that yields
// one quotient bit per stage, and five stages after it. Every stage
// advances together while the output register is free or being drained,
// so the throughput is one transfer per cycle. A zero divisor gives
// pressure 0 with divide_guard set. The user must write trim registers
// only while the pipeline is empty; the block does not enforce this.
module baro_pressure_compensation
  import bpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [TrimW-1:0]      cfg_data_i,
  bpc_stream_if.sink            in_if,
  bpc_stream_if.source          out_if
);
  logic [TrimW-1:0] temp_q, pa_q, pb_q, pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      pc_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTempTrim: temp_q <= cfg_data_i;
        RegPresA:    pa_q   <= cfg_data_i;
        RegPresB:    pb_q   <= cfg_data_i;
        RegPresC:    pc_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, temp_q[15:0]};
  assign t2 = sext16(temp_q[31:16]);
  assign t3 = sext16(temp_q[47:32]);
  assign p1 = {16'd0, pa_q[15:0]};
  assign p2 = sext16(pa_q[31:16]);
  assign p3 = sext16(pa_q[47:32]);
  assign p4 = sext16(pb_q[15:0]);
  assign p5 = sext16(pb_q[31:16]);
  assign p6 = sext16(pb_q[47:32]);
  assign p7 = sext16(pc_q[15:0]);
  assign p8 = sext16(pc_q[31:16]);
  assign p9 = sext16(pc_q[47:32]);

  // global advance: stall everything when the output holds an untaken result
  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || out_if.ready;
  assign in_if.ready = en;

  localparam int unsigned NS = 8;
  logic [NS:1] v_q;

  // stage 1: temperature differences
  logic [19:0] rp1_q;
  logic [31:0] ta1_q, td1_q;
  // stage 2: products
  logic [19:0] rp2_q;
  logic [31:0] ta2_q, tdd2_q;
  // stage 3
  logic [19:0] rp3_q;
  logic [31:0] ta3_q, tb3_q;
  // stage 4: fine temp, v1
  logic [19:0] rp4_q;
  logic [31:0] tf4_q, v4_q;
  // stage 5: q, v1*p5, p2*v1
  logic [19:0] rp5_q;
  logic [31:0] tf5_q, q5_q, m5a_q, m5b_q;
  // stage 6: q-products
  logic [19:0] rp6_q;
  logic [31:0] tf6_q, m6a_q, m6b_q, m5a6_q, m5b6_q;
  // stage 7: v2, v1 pre
  logic [19:0] rp7_q;
  logic [31:0] tf7_q, v27_q, v17_q;
  // stage 8: divisor product, numerator
  logic [31:0] tf8_q, mul8_q, num8_q;

  logic [31:0] d1a, d1b, tf4_d, v1c, q5c, v2c, v1s, den7c;
  assign d1a = {15'd0, in_if.data.raw_temperature[19:3]} - (t1 << 1);
  assign d1b = {16'd0, in_if.data.raw_temperature[19:4]} - t1;
  assign tf4_d = ta3_q + $unsigned($signed(tb3_q) >>> 14);
  assign v1c = $unsigned($signed(tf4_d) >>> 1) - Offs64000;
  assign q5c = $unsigned($signed(v4_q) >>> 2);
  assign v2c = m6a_q + (m5a6_q << 1);
  assign v1s = $unsigned($signed($unsigned($signed(m6b_q) >>> 3)
               + $unsigned($signed(m5b6_q) >>> 1)) >>> 18);
  assign den7c = Offs32768 + v17_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-1:1], in_if.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rp1_q  <= in_if.data.raw_pressure;
      ta1_q  <= d1a;
      td1_q  <= d1b;
      rp2_q  <= rp1_q;
      ta2_q  <= ta1_q * t2;
      tdd2_q <= td1_q * td1_q;
      rp3_q  <= rp2_q;
      ta3_q  <= $unsigned($signed(ta2_q) >>> 11);
      tb3_q  <= $unsigned($signed(tdd2_q) >>> 12) * t3;
      rp4_q  <= rp3_q;
      tf4_q  <= tf4_d;
      v4_q   <= v1c;
      rp5_q  <= rp4_q;
      tf5_q  <= tf4_q;
      q5_q   <= q5c * q5c;
      m5a_q  <= v4_q * p5;
      m5b_q  <= p2 * v4_q;
      rp6_q  <= rp5_q;
      tf6_q  <= tf5_q;
      m6a_q  <= $unsigned($signed(q5_q) >>> 11) * p6;
      m6b_q  <= p3 * $unsigned($signed(q5_q) >>> 13);
      m5a6_q <= m5a_q;
      m5b6_q <= m5b_q;
      rp7_q  <= rp6_q;
      tf7_q  <= tf6_q;
      v27_q  <= $unsigned($signed(v2c) >>> 2) + (p4 << 16);
      v17_q  <= v1s;
      tf8_q  <= tf7_q;
      mul8_q <= den7c * p1;
      num8_q <= ((Offs2p20 - {12'd0, rp7_q}) - $unsigned($signed(v27_q) >>> 12))
                * Scale3125;
    end
  end

  // stage 9: divisor and division branch
  typedef struct packed {
    logic [31:0] tf;
    logic        big;
    logic        guard;
  } side_t;

  logic [31:0] den8, num_pre;
  side_t       side_in, side_out;
  logic        big8;
  assign den8    = $unsigned($signed(mul8_q) >>> 15);
  assign big8    = (num8_q >= HalfRange);
  assign num_pre = big8 ? num8_q : (num8_q << 1);
  assign side_in = '{tf: tf8_q, big: big8, guard: (den8 == '0)};

  logic        dv_vld;
  logic [31:0] dv_quo;
  bpc_divider #(.SIDE_T(side_t)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[NS]),
    .num_i   (num_pre),
    .den_i   (den8),
    .side_i  (side_in),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (side_out)
  );

  // post-divide stages
  logic [31:0] pq;
  assign pq = side_out.big ? (dv_quo << 1) : dv_quo;

  logic [3:0]  w_q;
  logic [31:0] pa1_q, pa2_q, qa2_q, pa3_q, m9_q, m8_q, pa4_q, s4_q;
  side_t       sa1_q, sa2_q, sa3_q, sa4_q;
  logic [31:0] sq_c, sum_c;
  assign sq_c  = {3'd0, pa1_q[31:3]};
  assign sum_c = $unsigned($signed(m9_q) >>> 12) + $unsigned($signed(m8_q) >>> 13) + p7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else if (en) begin
      w_q <= {w_q[2:0], dv_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa1_q <= pq;
      sa1_q <= side_out;
      pa2_q <= pa1_q;
      qa2_q <= (sq_c * sq_c) >> 13;
      sa2_q <= sa1_q;
      pa3_q <= pa2_q;
      m9_q  <= p9 * qa2_q;
      m8_q  <= {2'd0, pa2_q[31:2]} * p8;
      sa3_q <= sa2_q;
      pa4_q <= pa3_q;
      s4_q  <= sum_c;
      sa4_q <= sa3_q;
    end
  end

  bpc_out_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= w_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q.pressure_pa      <= sa4_q.guard ? '0
                                : pa4_q + $unsigned($signed(s4_q) >>> 4);
      res_q.fine_temperature <= $signed(sa4_q.tf);
      res_q.divide_guard     <= sa4_q.guard;
    end
  end

  assign out_if.valid = out_vld_q;
  assign out_if.data  = res_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_if.ready |=> out_vld_q && $stable(res_q))
    else $error("result changed under stall");
  a_guard_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.divide_guard |-> res_q.pressure_pa == '0)
    else $error("guard without zero pressure");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_if.ready)
    else $error("input stalled with empty output");
`endif
endmodule

>>> hdl/bpc_divider.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bpc_divider #(
  parameter type SIDE_T = logic
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  input  SIDE_T       side_i,
  output logic        valid_o,
  output logic [31:0] quo_o,
  output SIDE_T       side_o
);
  localparam int unsigned N = 32;
  logic [N:1]      vld_q;
  logic [31:0]     rem_q [1:N];
  logic [31:0]     quo_q [1:N];
  logic [31:0]     den_q [1:N];
  SIDE_T           side_q [1:N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic        vld_c;
    logic [31:0] rem_c;
    logic [31:0] quo_c;
    logic [31:0] den_c;
    SIDE_T       side_c;
    logic [32:0] trial;
    logic [32:0] shr;
    if (s == 0) begin : g_head
      assign vld_c  = valid_i;
      assign rem_c  = '0;
      assign quo_c  = num_i;
      assign den_c  = den_i;
      assign side_c = side_i;
    end else begin : g_body
      assign vld_c  = vld_q[s];
      assign rem_c  = rem_q[s];
      assign quo_c  = quo_q[s];
      assign den_c  = den_q[s];
      assign side_c = side_q[s];
    end
    assign shr   = {rem_c, quo_c[31]};
    assign trial = shr - {1'b0, den_c};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_c;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!trial[32]) begin
          rem_q[s+1] <= trial[31:0];
          quo_q[s+1] <= {quo_c[30:0], 1'b1};
        end else begin
          rem_q[s+1] <= shr[31:0];
          quo_q[s+1] <= {quo_c[30:0], 1'b0};
        end
        den_q[s+1]  <= den_c;
        side_q[s+1] <= side_c;
      end
    end
  end

  assign valid_o = vld_q[N];
  assign quo_o   = quo_q[N];
  assign side_o  = side_q[N];
endmodule
